// File: hw/rtl/sha256_stream_hasher_unit_defines.svh
// Assertion macros shared by the checker.
`ifndef SHA256_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA256_STREAM_HASHER_UNIT_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define SHU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define SHU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/shu_pkg.sv
`timescale 1ns / 1ps
package shu_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenOffset  = 56;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned LenW       = 61;
  localparam logic [7:0]  PadByte    = 8'h80;
  localparam logic [LenW-1:0] MaxLength = {LenW{1'b1}};

  localparam logic REQ_DATA   = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  typedef logic [31:0] word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT,
    ST_ERR
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       wr_byte;     // store a byte at the fill position
    logic [7:0] wr_data;
    logic       pad_start;   // write the pad byte and begin padding
    logic       pad_step;    // write one fill/length byte
    logic       load;        // copy chaining value into the working set
    logic       round;       // perform one compression round
    logic       add;         // add working set into the chaining value
    logic       reset_msg;   // reload the initial hash, clear counters
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic block_full;        // 63 bytes are held; the next byte completes the block
    logic len_max;           // length counter saturated
    logic last_round;        // round counter at its final value
    logic pad_done;          // padding of the current block complete
    logic pad_final;         // the padded block holds the length field
  } stat_t;

  localparam word_t RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t ror32(input word_t v, input int unsigned n);
    ror32 = (v >> n) | (v << (32 - n));
  endfunction

endpackage

// File: hw/rtl/shu_in_if.sv
`timescale 1ns / 1ps
interface shu_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  modport source (output valid, req_type, data_byte, input ready);
  modport sink (input valid, req_type, data_byte, output ready);
endinterface

// File: hw/rtl/shu_out_if.sv
`timescale 1ns / 1ps
interface shu_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [1:0]  word_index;
  logic        last;
  logic        error;
  modport source (output valid, digest_word, word_index, last, error, input ready);
  modport sink (input valid, digest_word, word_index, last, error, output ready);
endinterface

// File: hw/rtl/shu_ctrl.sv
`timescale 1ns / 1ps
module shu_ctrl import shu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_req_type,
  input  logic [7:0] in_data_byte,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [1:0] emit_idx,
  output logic       emit_err,
  output cmd_t       cmd,
  input  stat_t      stat
);

  state_t     state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       finishing_r, finishing_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= 2'd0;
      finishing_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      finishing_r <= finishing_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    finishing_nxt = finishing_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_FINISH) begin
            state_nxt     = ST_PAD;
            finishing_nxt = 1'b1;
          end else if (stat.len_max) begin
            state_nxt = ST_ERR;
          end else if (stat.block_full) begin
            state_nxt     = ST_LOAD;
            finishing_nxt = 1'b0;
          end
        end
      end
      ST_PAD: if (stat.pad_done) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_ROUND;
      ST_ROUND: if (stat.last_round) state_nxt = ST_ADD;
      ST_ADD: begin
        if (!finishing_r) state_nxt = ST_IDLE;
        else if (stat.pad_final) begin
          state_nxt = ST_EMIT;
          idx_nxt   = 2'd0;
        end else state_nxt = ST_PAD;
      end
      ST_EMIT: begin
        if (out_ready) begin
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            state_nxt     = ST_IDLE;
            finishing_nxt = 1'b0;
          end
        end
      end
      ST_ERR: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    emit_idx  = idx_r;
    emit_err  = 1'b0;
    cmd.wr_data = in_data_byte;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_req_type == REQ_DATA && !stat.len_max) cmd.wr_byte = 1'b1;
        if (in_valid && in_req_type == REQ_FINISH) cmd.pad_start = 1'b1;
      end
      ST_PAD:   cmd.pad_step = !stat.pad_done;
      ST_LOAD:  cmd.load = 1'b1;
      ST_ROUND: cmd.round = 1'b1;
      ST_ADD:   cmd.add = 1'b1;
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready && idx_r == 2'd3) cmd.reset_msg = 1'b1;
      end
      ST_ERR: begin
        out_valid = 1'b1;
        emit_err  = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/shu_datapath.sv
`timescale 1ns / 1ps
module shu_datapath import shu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [1:0]  emit_idx,
  input  logic        emit_err,
  output logic [63:0] digest_word
);

  // The block buffer is held as sixteen big-endian schedule words; it doubles
  // as the 16-word rolling window of the message schedule during compression.
  word_t          w_r [16];
  word_t          h_r [8];
  word_t          s_r [8];
  logic [5:0]     fill_r;
  logic [LenW-1:0] len_r;
  logic [5:0]     rnd_r;
  logic [6:0]     pad_r;      // next byte position being padded; bit 6 marks the block end
  logic           pad_tail_r; // current padded block carries the length

  logic [63:0] bits;
  logic [7:0]  pad_byte;
  word_t       g0, g1, w_new, t1, t2, e, a;

  assign bits = {len_r, 3'b000};
  assign pad_byte = (pad_r[5:0] >= 6'(LenOffset) && pad_tail_r)
                  ? bits[8'(63 - 8 * pad_r[2:0]) -: 8] : 8'h00;

  assign stat.block_full = (fill_r == 6'(BlockBytes - 1));
  assign stat.len_max    = (len_r == MaxLength);
  assign stat.last_round = (rnd_r == 6'(Rounds - 1));
  assign stat.pad_done   = pad_r[6];
  assign stat.pad_final  = pad_tail_r;

  assign g0 = ror32(w_r[1], 7) ^ ror32(w_r[1], 18) ^ (w_r[1] >> 3);
  assign g1 = ror32(w_r[14], 17) ^ ror32(w_r[14], 19) ^ (w_r[14] >> 10);
  assign w_new = w_r[0] + g0 + w_r[9] + g1;
  assign e = s_r[4];
  assign a = s_r[0];
  assign t1 = s_r[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
            + ((e & s_r[5]) ^ (~e & s_r[6])) + RoundK[rnd_r] + w_r[0];
  assign t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
            + ((a & s_r[1]) ^ (a & s_r[2]) ^ (s_r[1] & s_r[2]));

  assign digest_word = emit_err ? 64'd0 : {h_r[{emit_idx, 1'b0}], h_r[{emit_idx, 1'b1}]};

  function automatic word_t put_byte(input word_t wd, input logic [1:0] pos,
                                     input logic [7:0] b);
    word_t r;
    r = wd;
    r[8'(31 - 8 * pos) -: 8] = b;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      len_r  <= '0;
      rnd_r  <= '0;
      pad_r  <= '0;
      pad_tail_r <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= InitHash[i];
    end else begin
      if (cmd.wr_byte) begin
        w_r[fill_r[5:2]] <= put_byte(w_r[fill_r[5:2]], fill_r[1:0], cmd.wr_data);
        fill_r <= fill_r + 6'd1;
        len_r  <= len_r + 1'b1;
      end
      if (cmd.pad_start) begin
        w_r[fill_r[5:2]] <= put_byte(w_r[fill_r[5:2]], fill_r[1:0], PadByte);
        pad_r  <= {1'b0, fill_r} + 7'd1;
        pad_tail_r <= (fill_r < 6'(LenOffset));
      end
      if (cmd.pad_step) begin
        w_r[pad_r[5:2]] <= put_byte(w_r[pad_r[5:2]], pad_r[1:0], pad_byte);
        pad_r <= pad_r + 7'd1;
      end
      if (cmd.load) begin
        for (int i = 0; i < 8; i++) s_r[i] <= h_r[i];
        rnd_r <= '0;
      end
      if (cmd.round) begin
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= w_new;
        s_r[7] <= s_r[6]; s_r[6] <= s_r[5]; s_r[5] <= s_r[4];
        s_r[4] <= s_r[3] + t1;
        s_r[3] <= s_r[2]; s_r[2] <= s_r[1]; s_r[1] <= s_r[0];
        s_r[0] <= t1 + t2;
        rnd_r <= rnd_r + 6'd1;
      end
      if (cmd.add) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + s_r[i];
        // A second padded block always carries the length.
        if (!pad_tail_r) begin
          pad_tail_r <= 1'b1;
          pad_r <= '0;
        end
      end
      if (cmd.reset_msg) begin
        for (int i = 0; i < 8; i++) h_r[i] <= InitHash[i];
        fill_r <= '0;
        len_r  <= '0;
        pad_tail_r <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/sha256_stream_hasher_unit.sv
`timescale 1ns / 1ps
// SHA-256 hasher over a byte stream. Each accepted word on the input carries
// either one message byte or a finish request. The 64th data byte of a
// block starts a compression (load, 64 rounds of one shared round unit,
// chaining add). A finish pads the block byte by byte, compresses once or
// twice, then offers four digest words, most significant first, the last one
// marked. A data byte beyond 2^61-1 bytes is dropped and answered with one
// error word. No input is taken while a block is compressed or while results
// are offered.
module sha256_stream_hasher_unit import shu_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  shu_in_if.sink    in_ch,
  shu_out_if.source out_ch
);

  cmd_t  cmd;
  stat_t stat;
  logic [1:0] emit_idx;
  logic       emit_err;

  // The controller sequences byte writes, padding, rounds and result delivery.
  shu_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_req_type  (in_ch.req_type),
    .in_data_byte (in_ch.data_byte),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .emit_idx, .emit_err, .cmd, .stat
  );

  // The datapath holds the buffer, schedule window, working set and hash.
  shu_datapath u_dp (
    .clk, .rst_n, .cmd, .stat, .emit_idx, .emit_err,
    .digest_word (out_ch.digest_word)
  );

  assign out_ch.word_index = emit_err ? 2'd0 : emit_idx;
  assign out_ch.last       = emit_err | (emit_idx == 2'd3);
  assign out_ch.error      = emit_err;

endmodule

// File: hw/rtl/shu_checker.sv
`timescale 1ns / 1ps
`include "sha256_stream_hasher_unit_defines.svh"
module shu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] digest_word,
  input logic [1:0]  word_index,
  input logic        last,
  input logic        error
);
  `SHU_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  `SHU_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && error, digest_word == 64'd0 && last)
  `SHU_ASSERT_IMP(a_last_idx, clk, rst_n, out_valid && !error, last == (word_index == 2'd3))
  `SHU_ASSERT_NEXT(a_seq, clk, rst_n, out_valid && out_ready && !last, out_valid && word_index == $past(word_index) + 2'd1)
endmodule

bind sha256_stream_hasher_unit shu_checker u_chk (
  .clk, .rst_n,
  .in_ready (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .digest_word (out_ch.digest_word),
  .word_index (out_ch.word_index),
  .last (out_ch.last),
  .error (out_ch.error)
);
